// File: hdl/spq_pkg.sv
// Package of the sorted-insert priority queue.
// Holds field widths, status and action codes, the entry key and cell control types and the ordering key function.
// No dependencies.
package spq_pkg;

    localparam int SCORE_BITS = 21;
    localparam int SEQ_BITS = 20;
    localparam int PAY_FIELD_BITS = 16;
    localparam int OCC_BITS = 7;
    localparam int STATUS_BITS = 2;
    localparam int KEY_BITS = 1 + 2 * SEQ_BITS;

    localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_POP = 1'b1;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [SEQ_BITS-1:0]   seq;
    } entry_key_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctl_t;

    // A negative score is infinite and sorts after every finite score.
    function automatic logic [KEY_BITS-1:0] order_key(input entry_key_t e);
        logic                inf;
        logic [SEQ_BITS-1:0] fin;
        inf = e.score[SCORE_BITS-1];
        fin = inf ? '0 : e.score[SEQ_BITS-1:0];
        return {inf, fin, e.seq};
    endfunction

endpackage

// File: hdl/spq_req_if.sv
// Request channel interface of the sorted-insert priority queue.
// Depends on spq_pkg for the field widths.
interface spq_req_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [SCORE_BITS-1:0]     score;
    logic [SEQ_BITS-1:0]       sequence_req;
    logic [PAY_FIELD_BITS-1:0] payload;

    modport source (output valid, output action, output score, output sequence_req,
                    output payload, input ready);
    modport sink (input valid, input action, input score, input sequence_req,
                  input payload, output ready);
endinterface

// File: hdl/spq_rsp_if.sv
// Response channel interface of the sorted-insert priority queue.
// Depends on spq_pkg for the field widths.
interface spq_rsp_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_BITS-1:0]    status;
    logic [SCORE_BITS-1:0]     popped_score;
    logic [SEQ_BITS-1:0]       popped_sequence;
    logic [PAY_FIELD_BITS-1:0] popped_payload;
    logic                      is_empty;
    logic [OCC_BITS-1:0]       occupancy;

    modport source (output valid, output status, output popped_score,
                    output popped_sequence, output popped_payload, output is_empty,
                    output occupancy, input ready);
    modport sink (input valid, input status, input popped_score, input popped_sequence,
                  input popped_payload, input is_empty, input occupancy, output ready);
endinterface

// File: hdl/sorted_insert_priority_queue_core.sv
// Top level of the sorted-insert minimum priority queue: a row of cells kept in pop order.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
//   channel   | modport | role
//   ----------+---------+--------------------------------------------------
//   request   | sink    | insert (action 0) or pop (action 1) transaction
//   response  | source  | one status/popped entry/occupancy transaction each
//
// On a request all cells compare the new key in parallel and shift in the same cycle, so
// a request can be accepted on every clock unless the response register is held.
// The response waits in an output register; a new request is accepted whenever that
// register is empty or is being taken in the same cycle.
// Reset clears the fill count and the response valid flag; cell contents stay undefined.
module sorted_insert_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    spq_req_if.sink    request,
    spq_rsp_if.source  response
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [STATUS_BITS-1:0]    status_reg, status_next;
    logic [SCORE_BITS-1:0]     score_reg, score_next;
    logic [SEQ_BITS-1:0]       seq_reg, seq_next;
    logic [PAY_FIELD_BITS-1:0] pay_reg, pay_next;
    logic                      empty_reg, empty_next;
    logic [OCC_BITS-1:0]       occ_reg, occ_next;

    logic       accept;
    logic       full;
    cell_ctl_t  ctl;
    entry_key_t new_key;

    logic [PAYLOAD_BITS-1:0]                new_pay;
    logic [PAYLOAD_BITS+PAY_FIELD_BITS-1:0] in_pay_ext;
    logic [PAYLOAD_BITS+PAY_FIELD_BITS-1:0] out_pay_ext;
    logic [CW+OCC_BITS-1:0]                 occ_ext;

    entry_key_t              cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
    logic                    cell_goes [DEPTH];

    assign request.ready = !out_valid_reg || response.ready;
    assign accept = request.valid && request.ready;
    assign full = (count_reg == CW'(DEPTH));

    assign ctl.ins = accept && (request.action == ACTION_INSERT) && !full;
    assign ctl.pop = accept && (request.action == ACTION_POP) && (count_reg != '0);

    assign new_key.score = request.score;
    assign new_key.seq = request.sequence_req;
    assign in_pay_ext = {{PAYLOAD_BITS{1'b0}}, request.payload};
    assign new_pay = in_pay_ext[PAYLOAD_BITS-1:0];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    left_goes;
            entry_key_t              left_key;
            logic [PAYLOAD_BITS-1:0] left_pay;
            entry_key_t              right_key;
            logic [PAYLOAD_BITS-1:0] right_pay;

            if (i == 0)
            begin : g_first
                assign left_goes = 1'b1;
                assign left_key = new_key;
                assign left_pay = new_pay;
            end
            else
            begin : g_inner_left
                assign left_goes = cell_goes[i-1];
                assign left_key = cell_key[i-1];
                assign left_pay = cell_pay[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_key = cell_key[i];
                assign right_pay = cell_pay[i];
            end
            else
            begin : g_inner_right
                assign right_key = cell_key[i+1];
                assign right_pay = cell_pay[i+1];
            end

            spq_cell #(
                .PAYLOAD_BITS(PAYLOAD_BITS)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (CW'(i) < count_reg),
                .new_key   (new_key),
                .new_pay   (new_pay),
                .left_goes (left_goes),
                .left_key  (left_key),
                .left_pay  (left_pay),
                .right_key (right_key),
                .right_pay (right_pay),
                .goes      (cell_goes[i]),
                .key       (cell_key[i]),
                .pay       (cell_pay[i])
            );
        end
    endgenerate

    assign out_pay_ext = {{PAY_FIELD_BITS{1'b0}}, cell_pay[0]};
    assign occ_ext = {{OCC_BITS{1'b0}}, count_next};

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        status_next = STATUS_OK;
        score_next = '0;
        seq_next = '0;
        pay_next = '0;
        if (request.action == ACTION_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
        end
        else if (count_reg == '0)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            score_next = cell_key[0].score;
            seq_next = cell_key[0].seq;
            pay_next = out_pay_ext[PAY_FIELD_BITS-1:0];
        end
        empty_next = (count_next == '0);
        occ_next = occ_ext[OCC_BITS-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            score_reg <= score_next;
            seq_reg <= seq_next;
            pay_reg <= pay_next;
            empty_reg <= empty_next;
            occ_reg <= occ_next;
        end
    end

    assign response.valid = out_valid_reg;
    assign response.status = status_reg;
    assign response.popped_score = score_reg;
    assign response.popped_sequence = seq_reg;
    assign response.popped_payload = pay_reg;
    assign response.is_empty = empty_reg;
    assign response.occupancy = occ_reg;

    // The fill count never passes the number of cells.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    // A successful pop removes exactly one entry.
    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not decrement fill count");

    // The first two held entries stay in pop order.
    a_head_order : assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && (count_reg >= CW'(2)) |->
            order_key(cell_key[0]) <= order_key(cell_key[1]))
        else $error("head entries out of order");

    // Every accepted request leaves a response waiting in the next cycle.
    a_rsp_follows : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request left no response");

endmodule

// File: hdl/spq_cell.sv
// One storage cell of the sorted queue: holds one entry and shifts with its neighbors.
// Depends on spq_pkg for the entry key type and the ordering key.
module spq_cell
    import spq_pkg::*;
#(
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic                    valid,
    input  entry_key_t              new_key,
    input  logic [PAYLOAD_BITS-1:0] new_pay,
    input  logic                    left_goes,
    input  entry_key_t              left_key,
    input  logic [PAYLOAD_BITS-1:0] left_pay,
    input  entry_key_t              right_key,
    input  logic [PAYLOAD_BITS-1:0] right_pay,
    output logic                    goes,
    output entry_key_t              key,
    output logic [PAYLOAD_BITS-1:0] pay
);

    entry_key_t              key_reg;
    entry_key_t              key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;

    // The cell keeps its entry on insert when the entry sorts at or before the new one.
    assign goes = valid && (order_key(key_reg) <= order_key(new_key));

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctl.pop)
        begin
            key_next = right_key;
            pay_next = right_pay;
        end
        else if (ctl.ins && !goes)
        begin
            key_next = left_goes ? new_key : left_key;
            pay_next = left_goes ? new_pay : left_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key = key_reg;
    assign pay = pay_reg;

endmodule

// File: sim/tb_sorted_insert_priority_queue_core.sv
// Self-checking testbench of the sorted-insert minimum priority queue core.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the core RTL; a scoreboard predicts each response.
module tb_sorted_insert_priority_queue_core
    import spq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int PAYLOAD_BITS = 16;
    localparam int ITEM_TARGET = 1050;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [SCORE_BITS-1:0]     score;
        logic [SEQ_BITS-1:0]       seq;
        logic [PAY_FIELD_BITS-1:0] pay;
    } slot_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [SCORE_BITS-1:0]     popped_score;
        logic [SEQ_BITS-1:0]       popped_sequence;
        logic [PAY_FIELD_BITS-1:0] popped_payload;
        logic                      is_empty;
        logic [OCC_BITS-1:0]       occupancy;
    } result_t;

    class spq_scoreboard;
        slot_t   held[$];
        result_t expected[$];
        int      errors;
        int      inserts;
        int      full_rejects;
        int      pops;
        int      empty_pops;
        int      peak;

        function logic [KEY_BITS-1:0] rank_of(slot_t s);
            logic                infinite;
            logic [SEQ_BITS-1:0] finite;
            infinite = s.score[SCORE_BITS-1];
            finite = infinite ? '0 : s.score[SEQ_BITS-1:0];
            return {infinite, finite, s.seq};
        endfunction

        function void note_request(logic act, slot_t item);
            result_t r;
            slot_t   head;
            int      pos;
            r = '0;
            if (act == ACTION_INSERT) begin
                inserts++;
                if (held.size() >= DEPTH) begin
                    r.status = STATUS_FULL;
                    full_rejects++;
                end else begin
                    pos = 0;
                    while (pos < held.size() && rank_of(held[pos]) <= rank_of(item))
                        pos++;
                    held.insert(pos, item);
                end
            end else begin
                pops++;
                if (held.size() == 0) begin
                    r.status = STATUS_EMPTY;
                    empty_pops++;
                end else begin
                    head = held.pop_front();
                    r.popped_score = head.score;
                    r.popped_sequence = head.seq;
                    r.popped_payload = head.pay;
                end
            end
            if (held.size() > peak)
                peak = held.size();
            r.is_empty = (held.size() == 0);
            r.occupancy = OCC_BITS'(held.size());
            expected.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected.size() == 0) begin
                $error("unexpected response transaction: status %0d occupancy %0d",
                       got.status, got.occupancy);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.popped_score !== want.popped_score) begin
                $error("popped_score: expected %0d, got %0d",
                       $signed(want.popped_score), $signed(got.popped_score));
                errors++;
            end
            if (got.popped_sequence !== want.popped_sequence) begin
                $error("popped_sequence: expected %0d, got %0d",
                       want.popped_sequence, got.popped_sequence);
                errors++;
            end
            if (got.popped_payload !== want.popped_payload) begin
                $error("popped_payload: expected %h, got %h",
                       want.popped_payload, got.popped_payload);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if request_ch();
    spq_rsp_if response_ch();

    spq_scoreboard sb = new();

    int items_sent;
    int burst_left;
    int idle_cycles;
    int rx_mode;
    int rx_left;

    sorted_insert_priority_queue_core #(
        .DEPTH       (DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .response(response_ch)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rx_left <= 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
            0: response_ch.ready <= 1'b1;
            1: response_ch.ready <= ($urandom_range(0, 9) < 7);
            2: response_ch.ready <= (rx_left % 4 != 0);
            default: response_ch.ready <= (rx_left % 24 >= 16);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (response_ch.valid && response_ch.ready)
                sb.check_result({response_ch.status, response_ch.popped_score,
                                 response_ch.popped_sequence, response_ch.popped_payload,
                                 response_ch.is_empty, response_ch.occupancy});
            if ((request_ch.valid && request_ch.ready)
                    || (response_ch.valid && response_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("sorted_insert_priority_queue_core verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic act, input logic [SCORE_BITS-1:0] score,
                             input logic [SEQ_BITS-1:0] seq,
                             input logic [PAY_FIELD_BITS-1:0] pay);
        int gap;
        @(negedge clk);
        request_ch.valid <= 1'b1;
        request_ch.action <= act;
        request_ch.score <= score;
        request_ch.sequence_req <= seq;
        request_ch.payload <= pay;
        do
            @(posedge clk);
        while (!request_ch.ready);
        sb.note_request(act, '{score: score, seq: seq, pay: pay});
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk) request_ch.valid <= 1'b0;
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 30);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk) request_ch.valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SCORE_BITS-1:0] pick_score();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: return {{(SCORE_BITS-3){1'b0}}, r[2:0]};
            3: return '1;
            4: return {1'b1, r[SEQ_BITS-1:0]};
            5: return '0;
            6: return {1'b0, {SEQ_BITS{1'b1}}};
            default: return {1'b0, r[SEQ_BITS-1:0]};
        endcase
    endfunction

    function automatic logic [SEQ_BITS-1:0] pick_seq();
        logic [31:0] r;
        r = $urandom;
        if (r[31])
            return {{(SEQ_BITS-2){1'b0}}, r[1:0]};
        return r[SEQ_BITS-1:0];
    endfunction

    initial
    begin
        int   phase;
        int   phase_len;
        int   mode;
        logic act;
        rst_n = 1'b0;
        request_ch.valid = 1'b0;
        request_ch.action = ACTION_INSERT;
        request_ch.score = '0;
        request_ch.sequence_req = '0;
        request_ch.payload = '0;
        response_ch.ready = 1'b0;
        items_sent = 0;
        burst_left = 8;
        idle_cycles = 0;
        rx_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_item(ACTION_POP, '1, '1, '1);
        send_item(ACTION_INSERT, 21'd5, 20'd3, 16'hFFFF);
        send_item(ACTION_INSERT, 21'd5, 20'd1, 16'h0000);
        send_item(ACTION_INSERT, 21'd5, 20'd1, 16'h1234);
        send_item(ACTION_INSERT, '1, 20'd7, 16'hAAAA);
        send_item(ACTION_INSERT, '1, 20'd2, 16'h5555);
        send_item(ACTION_INSERT, {1'b1, {SEQ_BITS{1'b0}}}, 20'd1, 16'h0F0F);
        send_item(ACTION_INSERT, 21'd0, {SEQ_BITS{1'b1}}, 16'hF0F0);
        send_item(ACTION_INSERT, {1'b0, {SEQ_BITS{1'b1}}}, 20'd0, 16'h8001);
        send_item(ACTION_INSERT, 21'd0, 20'd0, 16'h7FFE);
        repeat (10) send_item(ACTION_POP, '0, '0, '0);
        wait_drained();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 0) begin
                mode = 0;
                phase_len = 100;
            end else if (phase == 1) begin
                mode = 1;
                phase_len = 100;
            end else begin
                mode = $urandom_range(0, 2);
                phase_len = $urandom_range(10, 90);
            end
            repeat (phase_len) begin
                case (mode)
                    0: act = ($urandom_range(0, 9) == 0) ? ACTION_POP : ACTION_INSERT;
                    1: act = ($urandom_range(0, 9) == 0) ? ACTION_INSERT : ACTION_POP;
                    default: act = $urandom_range(0, 1) ? ACTION_POP : ACTION_INSERT;
                endcase
                send_item(act, pick_score(), pick_seq(), PAY_FIELD_BITS'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d inserts (%0d refused as full) and %0d pops (%0d on empty),",
                 sb.inserts, sb.full_rejects, sb.pops, sb.empty_pops);
        $display("with occupancy peaking at %0d of %0d entries.", sb.peak, DEPTH);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("sorted_insert_priority_queue_core verification clean");
        else
            $display("sorted_insert_priority_queue_core verification failed");
        $finish;
    end

endmodule
